### design/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared types and constants for the PS/2 mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int SIZE_W         = 13;
  localparam int LIMIT_W        = 7;
  localparam int CFG_IDX_W      = 3;
  localparam int QUEUE_DEPTH    = 2;

  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;
  localparam int LIMIT_RST  = 20;

  localparam logic       INVX_RST      = 1'b1;
  localparam logic       INVY_RST      = 1'b0;
  localparam int         SYNC_BIT      = 3;
  localparam logic [7:0] OVF_MASK      = 8'hC0;
  localparam int         BTN_W         = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_LIMIT  = 3'd2,
    CFG_INVX   = 3'd3,
    CFG_INVY   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HDR = 2'd0,
    PH_X   = 2'd1,
    PH_Y   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [BTN_W-1:0] buttons;
    logic [7:0]       dx_raw;
    logic [7:0]       dy_raw;
  } pkt_t;

endpackage

### design/ps2mct_framer.sv
// ----------------------------------------------------------------------------
// ps2mct_framer
// Frames three-byte packets, drops unsynced headers and overflow packets.
// ----------------------------------------------------------------------------
module ps2mct_framer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                resync_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output ps2mct_pkg::pkt_t    push_pkt_o
);

  ps2mct_pkg::phase_e phase_q, phase_d;
  logic [7:0]         hdr_q, x_q;
  logic               accept;
  logic               hdr_load, x_load;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      ps2mct_pkg::PH_HDR: begin
        if (accept && rx_byte_i[ps2mct_pkg::SYNC_BIT]) phase_d = ps2mct_pkg::PH_X;
      end
      ps2mct_pkg::PH_X: begin
        if (accept) phase_d = ps2mct_pkg::PH_Y;
      end
      ps2mct_pkg::PH_Y: begin
        if (accept) phase_d = ps2mct_pkg::PH_HDR;
      end
      default: phase_d = ps2mct_pkg::PH_HDR;
    endcase
    if (resync_i) phase_d = ps2mct_pkg::PH_HDR;
  end

  always_comb begin
    hdr_load     = 1'b0;
    x_load       = 1'b0;
    push_valid_o = 1'b0;
    case (phase_q)
      ps2mct_pkg::PH_HDR: hdr_load = accept && rx_byte_i[ps2mct_pkg::SYNC_BIT];
      ps2mct_pkg::PH_X:   x_load   = accept;
      ps2mct_pkg::PH_Y:   push_valid_o = in_valid_i && ((hdr_q & ps2mct_pkg::OVF_MASK) == 8'h00);
      default: ;
    endcase
  end

  assign push_pkt_o.buttons = hdr_q[ps2mct_pkg::BTN_W-1:0];
  assign push_pkt_o.dx_raw  = x_q;
  assign push_pkt_o.dy_raw  = rx_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ps2mct_pkg::PH_HDR;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_load) hdr_q <= rx_byte_i;
    if (x_load)   x_q   <= rx_byte_i;
  end

endmodule

### design/ps2mct_fifo.sv
// ----------------------------------------------------------------------------
// ps2mct_fifo
// Two-entry packet queue between the framer and the cursor engine.
// ----------------------------------------------------------------------------
module ps2mct_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  ps2mct_pkg::pkt_t push_pkt_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output ps2mct_pkg::pkt_t pop_pkt_o
);

  ps2mct_pkg::pkt_t mem_q [ps2mct_pkg::QUEUE_DEPTH];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'(ps2mct_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_pkt_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_pkt_i;
  end

endmodule

### design/ps2mct_cursor.sv
// ----------------------------------------------------------------------------
// ps2mct_cursor
// Config registers, delta clamp, cursor update and result register.
// ----------------------------------------------------------------------------
module ps2mct_cursor #(
  parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ps2mct_pkg::SIZE_W-1:0]        cfg_wdata_i,
  input  logic                                 pop_valid_i,
  output logic                                 pop_ready_o,
  input  ps2mct_pkg::pkt_t                     pop_pkt_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [7:0]                    delta_x_o,
  output logic signed [7:0]                    delta_y_o,
  output logic [COORD_BITS-1:0]                cursor_x_o,
  output logic [COORD_BITS-1:0]                cursor_y_o,
  output logic [ps2mct_pkg::BTN_W-1:0]         button_bits_o
);

  localparam int EW  = (ps2mct_pkg::SIZE_W > COORD_BITS + 1) ? ps2mct_pkg::SIZE_W
                                                             : COORD_BITS + 1;
  localparam int PW  = COORD_BITS + 2;
  localparam int MAXS = 1 << COORD_BITS;
  localparam int EFF_W_RST = (ps2mct_pkg::WIDTH_RST  > MAXS) ? MAXS : ps2mct_pkg::WIDTH_RST;
  localparam int EFF_H_RST = (ps2mct_pkg::HEIGHT_RST > MAXS) ? MAXS : ps2mct_pkg::HEIGHT_RST;

  logic [COORD_BITS:0]               eff_w_q, eff_h_q, eff_new;
  logic [ps2mct_pkg::LIMIT_W-1:0]    lim_q;
  logic                              invx_q, invy_q;
  logic [COORD_BITS-1:0]             pos_x_q, pos_y_q, pos_x_d, pos_y_d;
  logic [ps2mct_pkg::BTN_W-1:0]      last_btn_q;
  logic                              out_valid_q;
  logic [EW-1:0]                     wext, maxv;
  logic signed [7:0]                 dx, dy;
  logic signed [PW-1:0]              nx, ny;
  logic                              pop, emit;

  function automatic logic signed [7:0] clamp_d(input logic [7:0] b,
                                                input logic [ps2mct_pkg::LIMIT_W-1:0] lim);
    logic signed [8:0] s, l;
    s = {b[7], b};
    l = {2'b00, lim};
    if (s > l)       clamp_d = l[7:0];
    else if (s < -l) clamp_d = 8'(-l);
    else             clamp_d = s[7:0];
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_p(input logic signed [PW-1:0] p,
                                                    input logic [COORD_BITS:0] size);
    logic [COORD_BITS:0] top;
    top = size - 1'b1;
    if (p[PW-1])                   clamp_p = '0;
    else if (p[PW-2:0] >= size)    clamp_p = top[COORD_BITS-1:0];
    else                           clamp_p = p[COORD_BITS-1:0];
  endfunction

  always_comb begin
    wext = EW'(cfg_wdata_i);
    maxv = EW'(MAXS);
    if (wext == '0)       eff_new = (COORD_BITS+1)'(1);
    else if (wext > maxv) eff_new = maxv[COORD_BITS:0];
    else                  eff_new = wext[COORD_BITS:0];
  end

  assign pop_ready_o = ~out_valid_q | out_ready_i;
  assign pop         = pop_valid_i & pop_ready_o;

  always_comb begin
    dx = clamp_d(pop_pkt_i.dx_raw, lim_q);
    dy = clamp_d(pop_pkt_i.dy_raw, lim_q);
    nx = invx_q ? (PW'(pos_x_q) - PW'(dx)) : (PW'(pos_x_q) + PW'(dx));
    ny = invy_q ? (PW'(pos_y_q) + PW'(dy)) : (PW'(pos_y_q) - PW'(dy));
    pos_x_d = clamp_p(nx, eff_w_q);
    pos_y_d = clamp_p(ny, eff_h_q);
    emit = (dx != 8'sd0) || (dy != 8'sd0) || (pop_pkt_i.buttons != last_btn_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q     <= (COORD_BITS+1)'(EFF_W_RST);
      eff_h_q     <= (COORD_BITS+1)'(EFF_H_RST);
      lim_q       <= ps2mct_pkg::LIMIT_W'(ps2mct_pkg::LIMIT_RST);
      invx_q      <= ps2mct_pkg::INVX_RST;
      invy_q      <= ps2mct_pkg::INVY_RST;
      pos_x_q     <= COORD_BITS'(EFF_W_RST / 2);
      pos_y_q     <= COORD_BITS'(EFF_H_RST / 2);
      last_btn_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        pos_x_q <= pos_x_d;
        pos_y_q <= pos_y_d;
        if (emit) last_btn_q <= pop_pkt_i.buttons;
        out_valid_q <= emit;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (ps2mct_pkg::cfg_idx_e'(cfg_idx_i))
          ps2mct_pkg::CFG_WIDTH: begin
            eff_w_q    <= eff_new;
            pos_x_q    <= eff_new[COORD_BITS:1];
            pos_y_q    <= eff_h_q[COORD_BITS:1];
            last_btn_q <= '0;
          end
          ps2mct_pkg::CFG_HEIGHT: begin
            eff_h_q    <= eff_new;
            pos_x_q    <= eff_w_q[COORD_BITS:1];
            pos_y_q    <= eff_new[COORD_BITS:1];
            last_btn_q <= '0;
          end
          ps2mct_pkg::CFG_LIMIT: lim_q  <= cfg_wdata_i[ps2mct_pkg::LIMIT_W-1:0];
          ps2mct_pkg::CFG_INVX:  invx_q <= cfg_wdata_i[0];
          ps2mct_pkg::CFG_INVY:  invy_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && emit) begin
      delta_x_o     <= dx;
      delta_y_o     <= dy;
      cursor_x_o    <= pos_x_d;
      cursor_y_o    <= pos_y_d;
      button_bits_o <= pop_pkt_i.buttons;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### design/ps2_mouse_packet_cursor_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// Three-byte PS/2 mouse packet decoder driving a screen-clamped cursor.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the packet queue has room; the cursor
//   position register updates once per packet.
// Flow: a packet is queued when its third byte is accepted, and the result
//   register is loaded when the cursor engine pops it, unless an output stall holds it.
// Reset: async active low; cursor centered on 640x480, framing idle.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker #(
  parameter int COORD_BITS = ps2mct_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ps2mct_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ps2mct_pkg::SIZE_W-1:0]    cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [7:0]                delta_x_o,
  output logic signed [7:0]                delta_y_o,
  output logic [COORD_BITS-1:0]            cursor_x_o,
  output logic [COORD_BITS-1:0]            cursor_y_o,
  output logic [ps2mct_pkg::BTN_W-1:0]     button_bits_o
);

  logic             resync;
  logic             push_valid, push_ready, q_valid, q_ready;
  ps2mct_pkg::pkt_t push_pkt, q_pkt;

  assign resync = cfg_we_i &&
                  ((cfg_idx_i == ps2mct_pkg::CFG_WIDTH) || (cfg_idx_i == ps2mct_pkg::CFG_HEIGHT));

  ps2mct_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .resync_i     (resync),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_pkt_o   (push_pkt)
  );

  ps2mct_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_pkt_i   (push_pkt),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_pkt_o    (q_pkt)
  );

  ps2mct_cursor #(
    .COORD_BITS (COORD_BITS)
  ) u_cursor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pop_valid_i   (q_valid),
    .pop_ready_o   (q_ready),
    .pop_pkt_i     (q_pkt),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .delta_x_o     (delta_x_o),
    .delta_y_o     (delta_y_o),
    .cursor_x_o    (cursor_x_o),
    .cursor_y_o    (cursor_y_o),
    .button_bits_o (button_bits_o)
  );

`ifndef NO_ASSERTIONS
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid)
    else $error("queue full but reads empty");

  a_stall_holds_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && q_valid) |=> q_valid)
    else $error("queue drained while result stalled");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !q_ready)
    else $error("packet popped while result stalled");
`endif

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PS/2 mouse packet cursor tracker.
// Feeds mouse bytes with random gaps and output stalls, tracks framing, delta
// clamping and cursor motion in a local predictor, and checks each reported
// move in order against it.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W     = ps2mct_pkg::COORD_BITS_DEF;
  localparam int MAX_SPAN    = 1 << COORD_W;
  localparam int CFG_IDX_TOP = (1 << ps2mct_pkg::CFG_IDX_W) - 1;
  localparam int SIZE_TOP    = (1 << ps2mct_pkg::SIZE_W) - 1;
  localparam int LIMIT_TOP   = (1 << ps2mct_pkg::LIMIT_W) - 1;
  localparam int SETTLE_CYC  = 8;
  localparam int DRAIN_LIMIT = 5000;
  localparam int REPORT_MAX  = 10;

  typedef struct {
    logic signed [7:0]             dx;
    logic signed [7:0]             dy;
    logic [COORD_W-1:0]            cx;
    logic [COORD_W-1:0]            cy;
    logic [ps2mct_pkg::BTN_W-1:0]  btn;
  } move_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [ps2mct_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [ps2mct_pkg::SIZE_W-1:0]    cfg_wdata_i;
  logic                             in_valid_i;
  logic                             in_ready_o;
  logic [7:0]                       rx_byte_i;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic signed [7:0]                delta_x_o;
  logic signed [7:0]                delta_y_o;
  logic [COORD_W-1:0]               cursor_x_o;
  logic [COORD_W-1:0]               cursor_y_o;
  logic [ps2mct_pkg::BTN_W-1:0]     button_bits_o;

  // predictor state
  logic [ps2mct_pkg::SIZE_W-1:0]    scr_w_q;
  logic [ps2mct_pkg::SIZE_W-1:0]    scr_h_q;
  logic [ps2mct_pkg::LIMIT_W-1:0]   move_lim_q;
  logic                             flip_x_q;
  logic                             flip_y_q;
  ps2mct_pkg::phase_e               frame_ph;
  logic [7:0]                       hdr_q;
  logic [7:0]                       xraw_q;
  int                               pos_x_q;
  int                               pos_y_q;
  logic [ps2mct_pkg::BTN_W-1:0]     btn_q;

  move_t                 pending_moves[$];
  int                    mismatch_cnt = 0;
  int                    send_gap_pct = 0;
  int                    recv_gap_pct = 0;
  int                    hold_off_cyc = 0;

  ps2_mouse_packet_cursor_tracker dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int screen_span(logic [ps2mct_pkg::SIZE_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_SPAN) return MAX_SPAN;
    return int'(raw);
  endfunction

  function automatic int clamp_move(logic [7:0] raw);
    int d;
    int lim;
    d   = $signed(raw);
    lim = move_lim_q;
    if (d > lim) return lim;
    if (d < -lim) return -lim;
    return d;
  endfunction

  function automatic int clamp_pos(int p, int span);
    if (p < 0) return 0;
    if (p >= span) return span - 1;
    return p;
  endfunction

  function automatic void recenter_cursor();
    pos_x_q  = screen_span(scr_w_q) / 2;
    pos_y_q  = screen_span(scr_h_q) / 2;
    frame_ph = ps2mct_pkg::PH_HDR;
    btn_q    = '0;
  endfunction

  function automatic void reset_tracker();
    scr_w_q    = ps2mct_pkg::SIZE_W'(ps2mct_pkg::WIDTH_RST);
    scr_h_q    = ps2mct_pkg::SIZE_W'(ps2mct_pkg::HEIGHT_RST);
    move_lim_q = ps2mct_pkg::LIMIT_W'(ps2mct_pkg::LIMIT_RST);
    flip_x_q   = ps2mct_pkg::INVX_RST;
    flip_y_q   = ps2mct_pkg::INVY_RST;
    hdr_q      = '0;
    xraw_q     = '0;
    recenter_cursor();
  endfunction

  function automatic void apply_cfg(logic [ps2mct_pkg::CFG_IDX_W-1:0] idx,
                                    logic [ps2mct_pkg::SIZE_W-1:0] val);
    case (idx)
      ps2mct_pkg::CFG_WIDTH: begin
        scr_w_q = val;
        recenter_cursor();
      end
      ps2mct_pkg::CFG_HEIGHT: begin
        scr_h_q = val;
        recenter_cursor();
      end
      ps2mct_pkg::CFG_LIMIT: move_lim_q = val[ps2mct_pkg::LIMIT_W-1:0];
      ps2mct_pkg::CFG_INVX:  flip_x_q = val[0];
      ps2mct_pkg::CFG_INVY:  flip_y_q = val[0];
      default: ;
    endcase
  endfunction

  function automatic void track_rx_byte(logic [7:0] b);
    int    dx;
    int    dy;
    int    nx;
    int    ny;
    move_t m;
    case (frame_ph)
      ps2mct_pkg::PH_HDR: begin
        if (b[ps2mct_pkg::SYNC_BIT]) begin
          hdr_q    = b;
          frame_ph = ps2mct_pkg::PH_X;
        end
      end
      ps2mct_pkg::PH_X: begin
        xraw_q   = b;
        frame_ph = ps2mct_pkg::PH_Y;
      end
      default: begin
        frame_ph = ps2mct_pkg::PH_HDR;
        if ((hdr_q & ps2mct_pkg::OVF_MASK) == '0) begin
          dx      = clamp_move(xraw_q);
          dy      = clamp_move(b);
          nx      = flip_x_q ? pos_x_q - dx : pos_x_q + dx;
          ny      = flip_y_q ? pos_y_q + dy : pos_y_q - dy;
          pos_x_q = clamp_pos(nx, screen_span(scr_w_q));
          pos_y_q = clamp_pos(ny, screen_span(scr_h_q));
          if (dx != 0 || dy != 0 || hdr_q[ps2mct_pkg::BTN_W-1:0] != btn_q) begin
            btn_q = hdr_q[ps2mct_pkg::BTN_W-1:0];
            m.dx  = dx[7:0];
            m.dy  = dy[7:0];
            m.cx  = pos_x_q[COORD_W-1:0];
            m.cy  = pos_y_q[COORD_W-1:0];
            m.btn = btn_q;
            pending_moves.push_back(m);
          end
        end
      end
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX) $display("mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk_i) begin : check_moves
    move_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_moves.size() == 0) begin
        note_mismatch($sformatf("unexpected move dx=%0d dy=%0d x=%0d y=%0d btn=%0h",
                                delta_x_o, delta_y_o, cursor_x_o, cursor_y_o,
                                button_bits_o));
      end else begin
        e = pending_moves.pop_front();
        if (delta_x_o !== e.dx || delta_y_o !== e.dy || cursor_x_o !== e.cx ||
            cursor_y_o !== e.cy || button_bits_o !== e.btn) begin
          note_mismatch($sformatf(
            "exp dx=%0d dy=%0d x=%0d y=%0d btn=%0h, got dx=%0d dy=%0d x=%0d y=%0d btn=%0h",
            e.dx, e.dy, e.cx, e.cy, e.btn,
            delta_x_o, delta_y_o, cursor_x_o, cursor_y_o, button_bits_o));
        end
      end
    end
  end

  // receiver: long hold-off when requested, random stalls otherwise
  always @(negedge clk_i) begin
    if (hold_off_cyc > 0) begin
      out_ready_i <= 1'b0;
      hold_off_cyc = hold_off_cyc - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  task automatic send_byte(logic [7:0] b);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    track_rx_byte(b);
    @(negedge clk_i);
  endtask

  task automatic send_packet(logic [7:0] hdr, logic [7:0] xb, logic [7:0] yb);
    send_byte(hdr);
    send_byte(xb);
    send_byte(yb);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_moves.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [ps2mct_pkg::CFG_IDX_W-1:0] idx,
                           logic [ps2mct_pkg::SIZE_W-1:0] val);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    apply_cfg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] rand_header();
    logic [7:0] h;
    h                       = 8'($urandom);
    h[ps2mct_pkg::SYNC_BIT] = 1'b1;
    if ($urandom_range(9) != 0) h = h & ~ps2mct_pkg::OVF_MASK;
    return h;
  endfunction

  function automatic logic [7:0] rand_move();
    case ($urandom_range(3))
      0:       return '0;
      1:       return 8'($urandom_range(0, 6) - 3);
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [ps2mct_pkg::SIZE_W-1:0] pick_size();
    case ($urandom_range(7))
      0:       return '0;
      1:       return ps2mct_pkg::SIZE_W'(1);
      2:       return ps2mct_pkg::SIZE_W'(MAX_SPAN);
      3:       return ps2mct_pkg::SIZE_W'($urandom_range(MAX_SPAN + 1, SIZE_TOP));
      default: return ps2mct_pkg::SIZE_W'($urandom_range(2, 64));
    endcase
  endfunction

  function automatic logic [ps2mct_pkg::SIZE_W-1:0] pick_limit();
    case ($urandom_range(3))
      0:       return '0;
      1:       return ps2mct_pkg::SIZE_W'(LIMIT_TOP);
      default: return ps2mct_pkg::SIZE_W'($urandom_range(0, SIZE_TOP));
    endcase
  endfunction

  task automatic tweak_register();
    case ($urandom_range(ps2mct_pkg::CFG_INVY))
      ps2mct_pkg::CFG_WIDTH:  cfg_write(ps2mct_pkg::CFG_WIDTH, pick_size());
      ps2mct_pkg::CFG_HEIGHT: cfg_write(ps2mct_pkg::CFG_HEIGHT, pick_size());
      ps2mct_pkg::CFG_LIMIT:  cfg_write(ps2mct_pkg::CFG_LIMIT, pick_limit());
      ps2mct_pkg::CFG_INVX:
        cfg_write(ps2mct_pkg::CFG_INVX, ps2mct_pkg::SIZE_W'($urandom_range(0, SIZE_TOP)));
      default:
        cfg_write(ps2mct_pkg::CFG_INVY, ps2mct_pkg::SIZE_W'($urandom_range(0, SIZE_TOP)));
    endcase
  endtask

  task automatic test_framing_and_overflow();
    // bytes without the sync bit are dropped while hunting for a header
    send_byte(8'h00);
    send_byte(8'hF7);
    send_packet(8'h08, 8'h7F, 8'h80);
    // button change alone, then a repeat that reports nothing
    send_packet(8'h0F, 8'h00, 8'h00);
    send_packet(8'h0F, 8'h00, 8'h00);
    // overflow on x, on y, on both
    send_packet(8'h4F, 8'h10, 8'h10);
    send_packet(8'h8F, 8'hF0, 8'h10);
    send_packet(8'hC8, 8'h7F, 8'h7F);
    // header sign bits do not affect deltas
    send_packet(8'h38, 8'h05, 8'hFB);
    send_packet(8'h09, 8'hFF, 8'h01);
  endtask

  task automatic test_delta_and_screen_extremes();
    // -128 clamps to -127 at the widest limit
    cfg_write(ps2mct_pkg::CFG_LIMIT, ps2mct_pkg::SIZE_W'(LIMIT_TOP));
    send_packet(8'h08, 8'h80, 8'h80);
    send_packet(8'h08, 8'h7F, 8'h7F);
    // zero limit: only button changes report
    cfg_write(ps2mct_pkg::CFG_LIMIT, '0);
    send_packet(8'h08, 8'h55, 8'hAA);
    send_packet(8'h0A, 8'h7F, 8'h80);
    // zero width acts as one, oversize height acts as the full range
    cfg_write(ps2mct_pkg::CFG_WIDTH, '0);
    cfg_write(ps2mct_pkg::CFG_HEIGHT, ps2mct_pkg::SIZE_W'(SIZE_TOP));
    cfg_write(ps2mct_pkg::CFG_LIMIT, ps2mct_pkg::SIZE_W'(LIMIT_TOP));
    cfg_write(ps2mct_pkg::CFG_INVX, '0);
    cfg_write(ps2mct_pkg::CFG_INVY, ps2mct_pkg::SIZE_W'(1));
    repeat (20) send_packet(8'h08, 8'h7F, 8'h7F);
    repeat (20) send_packet(8'h09, 8'h80, 8'h80);
    cfg_write(ps2mct_pkg::CFG_WIDTH, ps2mct_pkg::SIZE_W'(MAX_SPAN));
    cfg_write(ps2mct_pkg::CFG_HEIGHT, ps2mct_pkg::SIZE_W'(1));
    repeat (20) send_packet(8'h0C, 8'h7F, 8'h81);
    repeat (20) send_packet(8'h0D, 8'h81, 8'h7F);
    cfg_write(ps2mct_pkg::CFG_INVX, ps2mct_pkg::SIZE_W'(1));
    cfg_write(ps2mct_pkg::CFG_INVY, '0);
    repeat (20) send_packet(8'h08, 8'h80, 8'h7F);
    // register writes land between bytes of a packet
    cfg_write(ps2mct_pkg::CFG_WIDTH, ps2mct_pkg::SIZE_W'(100));
    send_byte(8'h0B);
    cfg_write(ps2mct_pkg::CFG_LIMIT, ps2mct_pkg::SIZE_W'(5));
    send_byte(8'h20);
    send_byte(8'hE0);
    send_byte(8'h0B);
    cfg_write(ps2mct_pkg::CFG_HEIGHT, ps2mct_pkg::SIZE_W'(50));
    send_packet(8'h0E, 8'h02, 8'h03);
    // writes to unmapped indexes change nothing
    for (int i = ps2mct_pkg::CFG_INVY + 1; i <= CFG_IDX_TOP; i++) begin
      cfg_write(ps2mct_pkg::CFG_IDX_W'(i),
                ps2mct_pkg::SIZE_W'($urandom_range(0, SIZE_TOP)));
    end
    send_packet(8'h08, 8'h03, 8'hFD);
    cfg_write(ps2mct_pkg::CFG_WIDTH, ps2mct_pkg::SIZE_W'(ps2mct_pkg::WIDTH_RST));
    cfg_write(ps2mct_pkg::CFG_HEIGHT, ps2mct_pkg::SIZE_W'(ps2mct_pkg::HEIGHT_RST));
    cfg_write(ps2mct_pkg::CFG_LIMIT, ps2mct_pkg::SIZE_W'(LIMIT_TOP));
  endtask

  task automatic test_output_stall();
    send_gap_pct = 0;
    hold_off_cyc = 300;
    repeat (40) begin
      send_packet(rand_header() & ~ps2mct_pkg::OVF_MASK, 8'($urandom) | 8'h01,
                  rand_move());
    end
    settle();
  endtask

  task automatic test_random_traffic(int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(99) < 3) tweak_register();
      if ($urandom_range(9) == 0) begin
        send_byte(8'($urandom));
        sent++;
      end else begin
        send_packet(rand_header(), rand_move(), rand_move());
        sent += 3;
      end
    end
    settle();
  endtask

  initial begin : run_tests
    int wait_cyc;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    rx_byte_i    = '0;
    send_gap_pct = 25;
    recv_gap_pct = 77;
    reset_tracker();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_framing_and_overflow();
    test_delta_and_screen_extremes();
    test_output_stall();
    send_gap_pct = 25;
    recv_gap_pct = 77;
    test_random_traffic(300);
    send_gap_pct = 77;
    recv_gap_pct = 25;
    test_random_traffic(300);
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_traffic(300);

    in_valid_i <= 1'b0;
    wait_cyc = 0;
    while (pending_moves.size() != 0 && wait_cyc < DRAIN_LIMIT) begin
      @(negedge clk_i);
      wait_cyc++;
    end
    repeat (SETTLE_CYC) @(negedge clk_i);
    if (pending_moves.size() != 0) begin
      note_mismatch($sformatf("%0d moves never reported", pending_moves.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
